@@ hdl/optimal_bst_builder_top_defines.svh @@
// assertion macros for the optimal bst builder checker
// no dependencies; included by the checker file
`ifndef OPTIMAL_BST_BUILDER_TOP_DEFINES_SVH
`define OPTIMAL_BST_BUILDER_TOP_DEFINES_SVH

// property checked outside reset
`define OBST_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("obst check failed");

// property checked at every edge, reset included
`define OBST_CHK_ALL(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("obst reset check failed");

`endif

@@ hdl/obst_pkg.sv @@
// shared types and constants of the optimal bst builder
// no dependencies
package obst_pkg;

  localparam int KEY_W      = 16;
  localparam int WT_W       = 16;
  localparam int OUT_IDX_W  = 6;
  localparam int COST_W     = 32;
  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic [KEY_W-1:0] key_value;
    logic [WT_W-1:0]  weight;
    logic             last_key;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]     node_key;
    logic [OUT_IDX_W-1:0] node_index;
    logic [OUT_IDX_W-1:0] node_level;
    logic [COST_W-1:0]    total_cost;
    logic                 last_node;
  } out_item_t;

  // head of the request queue as seen by the back end
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } queue_head_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_WRD,
    ST_WSUB,
    ST_CRD,
    ST_CSUM,
    ST_CCMP,
    ST_CWR,
    ST_TOT,
    ST_TOTD,
    ST_TRD,
    ST_TKEY,
    ST_TEMIT,
    ST_TPOP,
    ST_TPOPD
  } back_state_t;

endpackage

@@ hdl/optimal_bst_builder_top.sv @@
// top level of the optimal binary search tree builder
// depends on obst_pkg, obst_front, obst_back and obst_ram
//
// channel   ports                        handshake
// input     start, busy, in_data         accepted when start and not busy
// result    out_valid, out_data          one-cycle strobe, never stalled
//
// keys are taken one per cycle, unless busy, into a four-entry request
// queue; the back end drains it one key per cycle while loading
// after the last key, each range [i..j] reads and subtracts two prefix sums;
// the root loop reads two cost ram copies, sums, then compares, per root,
// then writes its best cost and root; the whole tree's total cost is read last
// the walk reads each root, then its key, then emits; pops read the stack
// requests keep queueing during a burst; busy rises only when the queue fills
// reset clears control state; the key, prefix and range rams need no clear
module optimal_bst_builder_top #(
  parameter int MAX_KEYS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  obst_pkg::in_item_t  in_data,
  output logic                out_valid,
  output obst_pkg::out_item_t out_data
);

  // queue head handed from front to back, pop handed back
  obst_pkg::queue_head_t q_head;
  logic                  q_pop;

  // front: request acceptance and queue
  obst_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .q_pop(q_pop), .q_head(q_head)
  );

  // back: key load, cost program, preorder walk and result strobe
  obst_back #(.MAX_KEYS(MAX_KEYS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_head(q_head), .q_pop(q_pop),
    .out_valid(out_valid), .out_data(out_data)
  );

endmodule

@@ hdl/obst_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
module obst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/obst_front.sv @@
// front end: request acceptance and a short request queue
// depends on obst_pkg
module obst_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  obst_pkg::in_item_t   in_data,
  input  logic                 q_pop,
  output obst_pkg::queue_head_t q_head
);

  localparam int PTR_W = $clog2(obst_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(obst_pkg::FIFO_DEPTH + 1);

  obst_pkg::in_item_t fifo_r [obst_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;
  logic             pop;

  assign busy   = (cnt_r == CNT_W'(obst_pkg::FIFO_DEPTH));
  assign push   = start && !busy;
  assign pop    = q_pop && (cnt_r != '0);
  assign q_head = '{valid: (cnt_r != '0), item: fifo_r[rd_ptr_r]};

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

@@ hdl/obst_back.sv @@
// back end: key loading, range cost program and preorder tree walk
// depends on obst_pkg and obst_ram
module obst_back #(
  parameter int MAX_KEYS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  obst_pkg::queue_head_t q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  output obst_pkg::out_item_t   out_data
);

  localparam int IDX_W  = $clog2(MAX_KEYS);
  localparam int CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int SUM_W  = obst_pkg::WT_W + IDX_W;
  localparam int CELL_W = 2 * IDX_W;
  localparam int CELLS  = 1 << CELL_W;
  localparam int STK_W  = 3 * IDX_W;
  localparam int CW     = obst_pkg::COST_W;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? '1 : s[CW-1:0];
  endfunction

  obst_pkg::back_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [IDX_W-1:0] d_r, d_nxt, i_r, i_nxt, r_r, r_nxt;
  logic [SUM_W-1:0] w_r, w_nxt;
  logic [CW-1:0]    s1_r, s1_nxt, best_r, best_nxt, total_r, total_nxt;
  logic [IDX_W-1:0] best_root_r, best_root_nxt, root_r, root_nxt;
  logic [IDX_W-1:0] cur_f_r, cur_f_nxt, cur_l_r, cur_l_nxt, cur_lv_r, cur_lv_nxt;
  logic [CNT_W-1:0] sp_r, sp_nxt, emitted_r, emitted_nxt;
  logic             out_valid_r, out_valid_nxt;
  obst_pkg::out_item_t out_data_r, out_data_nxt;

  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] n_last;
  logic [CW-1:0]    left_c, right_c, cand;

  // memory ports
  logic                       key_we, pre_we;
  logic [IDX_W-1:0]           key_ra, pa_ra, pb_ra;
  logic [obst_pkg::KEY_W-1:0] key_rd;
  logic [SUM_W-1:0]           pre_wd, pa_rd, pb_rd;
  logic                       cost_we;
  logic [CELL_W-1:0]          cell_wa, ca_ra, cb_ra, rt_ra;
  logic [CW-1:0]              ca_rd, cb_rd;
  logic [IDX_W-1:0]           rt_rd;
  logic                       stk_we;
  logic [IDX_W-1:0]           stk_wa, stk_ra;
  logic [STK_W-1:0]           stk_wd, stk_rd;

  assign j      = i_r + d_r;
  assign n_last = IDX_W'(count_r - 1'b1);
  assign left_c  = (r_r == i_r) ? '0 : ca_rd;
  assign right_c = (r_r == j) ? '0 : cb_rd;
  assign cand    = sat_add(s1_r, CW'(w_r));
  assign pre_wd  = sum_r + SUM_W'(q_head.item.weight);
  assign cell_wa = {i_r, j};

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    d_nxt         = d_r;
    i_nxt         = i_r;
    r_nxt         = r_r;
    w_nxt         = w_r;
    s1_nxt        = s1_r;
    best_nxt      = best_r;
    best_root_nxt = best_root_r;
    total_nxt     = total_r;
    root_nxt      = root_r;
    cur_f_nxt     = cur_f_r;
    cur_l_nxt     = cur_l_r;
    cur_lv_nxt    = cur_lv_r;
    sp_nxt        = sp_r;
    emitted_nxt   = emitted_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    q_pop   = 1'b0;
    key_we  = 1'b0;
    pre_we  = 1'b0;
    key_ra  = '0;
    pa_ra   = '0;
    pb_ra   = '0;
    cost_we = 1'b0;
    ca_ra   = '0;
    cb_ra   = '0;
    rt_ra   = '0;
    stk_we  = 1'b0;
    stk_wa  = sp_r[IDX_W-1:0];
    stk_wd  = '0;
    stk_ra  = '0;
    case (state_r)
      obst_pkg::ST_LOAD: begin
        if (q_head.valid) begin
          q_pop = 1'b1;
          if (count_r < CNT_W'(MAX_KEYS)) begin
            key_we    = 1'b1;
            pre_we    = 1'b1;
            sum_nxt   = pre_wd;
            count_nxt = count_r + 1'b1;
          end
          if (q_head.item.last_key) begin
            d_nxt     = '0;
            i_nxt     = '0;
            state_nxt = obst_pkg::ST_WRD;
          end
        end
      end
      obst_pkg::ST_WRD: begin
        pa_ra     = j;
        pb_ra     = i_r - 1'b1;
        state_nxt = obst_pkg::ST_WSUB;
      end
      obst_pkg::ST_WSUB: begin
        w_nxt     = pa_rd - ((i_r == '0) ? '0 : pb_rd);
        r_nxt     = i_r;
        state_nxt = obst_pkg::ST_CRD;
      end
      obst_pkg::ST_CRD: begin
        ca_ra     = {i_r, r_r - 1'b1};
        cb_ra     = {r_r + 1'b1, j};
        state_nxt = obst_pkg::ST_CSUM;
      end
      obst_pkg::ST_CSUM: begin
        s1_nxt    = sat_add(left_c, right_c);
        state_nxt = obst_pkg::ST_CCMP;
      end
      obst_pkg::ST_CCMP: begin
        if (r_r == i_r || cand < best_r) begin
          best_nxt      = cand;
          best_root_nxt = r_r;
        end
        if (r_r == j) begin
          state_nxt = obst_pkg::ST_CWR;
        end else begin
          r_nxt     = r_r + 1'b1;
          state_nxt = obst_pkg::ST_CRD;
        end
      end
      obst_pkg::ST_CWR: begin
        cost_we = 1'b1;
        if (j == n_last) begin
          if (d_r == n_last) begin
            state_nxt = obst_pkg::ST_TOT;
          end else begin
            d_nxt     = d_r + 1'b1;
            i_nxt     = '0;
            state_nxt = obst_pkg::ST_WRD;
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = obst_pkg::ST_WRD;
        end
      end
      obst_pkg::ST_TOT: begin
        ca_ra       = {{IDX_W{1'b0}}, n_last};
        cur_f_nxt   = '0;
        cur_l_nxt   = n_last;
        cur_lv_nxt  = '0;
        sp_nxt      = '0;
        emitted_nxt = '0;
        state_nxt   = obst_pkg::ST_TOTD;
      end
      obst_pkg::ST_TOTD: begin
        total_nxt = ca_rd;
        state_nxt = obst_pkg::ST_TRD;
      end
      obst_pkg::ST_TRD: begin
        rt_ra     = {cur_f_r, cur_l_r};
        state_nxt = obst_pkg::ST_TKEY;
      end
      obst_pkg::ST_TKEY: begin
        root_nxt  = rt_rd;
        key_ra    = rt_rd;
        state_nxt = obst_pkg::ST_TEMIT;
      end
      obst_pkg::ST_TEMIT: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.node_key   = key_rd;
        out_data_nxt.node_index = obst_pkg::OUT_IDX_W'(root_r);
        out_data_nxt.node_level = obst_pkg::OUT_IDX_W'(cur_lv_r);
        out_data_nxt.total_cost = total_r;
        out_data_nxt.last_node  = (emitted_r + 1'b1 == count_r);
        emitted_nxt             = emitted_r + 1'b1;
        if (emitted_r + 1'b1 == count_r) begin
          count_nxt = '0;
          sum_nxt   = '0;
          state_nxt = obst_pkg::ST_LOAD;
        end else if (root_r > cur_f_r) begin
          if (root_r < cur_l_r) begin
            stk_we = 1'b1;
            stk_wd = {root_r + 1'b1, cur_l_r, cur_lv_r + 1'b1};
            sp_nxt = sp_r + 1'b1;
          end
          cur_l_nxt  = root_r - 1'b1;
          cur_lv_nxt = cur_lv_r + 1'b1;
          state_nxt  = obst_pkg::ST_TRD;
        end else if (root_r < cur_l_r) begin
          cur_f_nxt  = root_r + 1'b1;
          cur_lv_nxt = cur_lv_r + 1'b1;
          state_nxt  = obst_pkg::ST_TRD;
        end else begin
          state_nxt = obst_pkg::ST_TPOP;
        end
      end
      obst_pkg::ST_TPOP: begin
        stk_ra    = IDX_W'(sp_r - 1'b1);
        sp_nxt    = sp_r - 1'b1;
        state_nxt = obst_pkg::ST_TPOPD;
      end
      obst_pkg::ST_TPOPD: begin
        cur_f_nxt  = stk_rd[STK_W-1 -: IDX_W];
        cur_l_nxt  = stk_rd[2*IDX_W-1 -: IDX_W];
        cur_lv_nxt = stk_rd[IDX_W-1:0];
        state_nxt  = obst_pkg::ST_TRD;
      end
      default: begin
        state_nxt = obst_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= obst_pkg::ST_LOAD;
      count_r     <= '0;
      sum_r       <= '0;
      sp_r        <= '0;
      emitted_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      sp_r        <= sp_nxt;
      emitted_r   <= emitted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r         <= d_nxt;
    i_r         <= i_nxt;
    r_r         <= r_nxt;
    w_r         <= w_nxt;
    s1_r        <= s1_nxt;
    best_r      <= best_nxt;
    best_root_r <= best_root_nxt;
    total_r     <= total_nxt;
    root_r      <= root_nxt;
    cur_f_r     <= cur_f_nxt;
    cur_l_r     <= cur_l_nxt;
    cur_lv_r    <= cur_lv_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  obst_ram #(.WIDTH(obst_pkg::KEY_W), .DEPTH(MAX_KEYS)) u_key_ram (
    .clk(clk), .we(key_we), .wr_addr(count_r[IDX_W-1:0]),
    .wr_data(q_head.item.key_value), .rd_addr(key_ra), .rd_data(key_rd)
  );

  // two copies of the prefix sums for two reads a cycle
  obst_ram #(.WIDTH(SUM_W), .DEPTH(MAX_KEYS)) u_pre_a_ram (
    .clk(clk), .we(pre_we), .wr_addr(count_r[IDX_W-1:0]),
    .wr_data(pre_wd), .rd_addr(pa_ra), .rd_data(pa_rd)
  );

  obst_ram #(.WIDTH(SUM_W), .DEPTH(MAX_KEYS)) u_pre_b_ram (
    .clk(clk), .we(pre_we), .wr_addr(count_r[IDX_W-1:0]),
    .wr_data(pre_wd), .rd_addr(pb_ra), .rd_data(pb_rd)
  );

  // two copies of the range costs for left and right subtrees
  obst_ram #(.WIDTH(CW), .DEPTH(CELLS)) u_cost_a_ram (
    .clk(clk), .we(cost_we), .wr_addr(cell_wa),
    .wr_data(best_r), .rd_addr(ca_ra), .rd_data(ca_rd)
  );

  obst_ram #(.WIDTH(CW), .DEPTH(CELLS)) u_cost_b_ram (
    .clk(clk), .we(cost_we), .wr_addr(cell_wa),
    .wr_data(best_r), .rd_addr(cb_ra), .rd_data(cb_rd)
  );

  obst_ram #(.WIDTH(IDX_W), .DEPTH(CELLS)) u_root_ram (
    .clk(clk), .we(cost_we), .wr_addr(cell_wa),
    .wr_data(best_root_r), .rd_addr(rt_ra), .rd_data(rt_rd)
  );

  obst_ram #(.WIDTH(STK_W), .DEPTH(MAX_KEYS)) u_stack_ram (
    .clk(clk), .we(stk_we), .wr_addr(stk_wa),
    .wr_data(stk_wd), .rd_addr(stk_ra), .rd_data(stk_rd)
  );

endmodule

@@ hdl/obst_checker.sv @@
// port-level checks of the optimal bst builder, bound to the top level
// depends on obst_pkg and optimal_bst_builder_top_defines.svh
`include "optimal_bst_builder_top_defines.svh"

module obst_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input obst_pkg::out_item_t out_data
);

  // every node needs a root lookup, so strobes never come back to back
  `OBST_CHK(a_strobe_gap, out_valid |=> !out_valid)

  // the queue fills only through accepted requests
  `OBST_CHK(a_busy_after_start, $rose(busy) |-> $past(start))

  // a strobed node carries no unknown bits
  `OBST_CHK(a_node_known, out_valid |-> !$isunknown(out_data))

  // nothing leaves and the queue is empty right after reset
  `OBST_CHK_ALL(a_reset_quiet, !rst_n |=> (!out_valid && !busy))

endmodule

bind optimal_bst_builder_top obst_checker u_obst_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_data(out_data)
);
